@@ hw/rtl/ulcf_pkg.sv @@
// Shared types and constants of the universal-life commutation unit.
// No dependencies; imported by every module of the block.
package ulcf_pkg;

  localparam int OP_W = 36;
  localparam int RES_W = 40;
  localparam int SERIAL_STEPS = 36;

  localparam logic [32:0] FX_ONE = 33'h1_0000_0000;
  localparam logic [31:0] RATE_MAX = 32'h8000_0000;
  localparam logic [35:0] KC_MAX = 36'hC_0000_0000;

  localparam logic [1:0] CFG_PERIODS = 2'd0;
  localparam logic [1:0] CFG_OPTION = 2'd1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_SEQ      = 2'd1,
    ST_UNLOADED = 2'd2
  } status_e;

  typedef struct packed {
    logic            start;
    logic [OP_W-1:0] a;
    logic [OP_W-1:0] b;
  } unit_req_t;

  typedef struct packed {
    logic             done;
    logic [RES_W-1:0] res;
  } unit_rsp_t;

  typedef struct packed {
    logic [32:0] ad;
    logic [35:0] kd;
    logic [35:0] kc;
    logic [39:0] dpre;
    logic [42:0] cpre;
  } entry_t;

  function automatic logic periods_ok(logic [3:0] p);
    logic r;
    case (p)
      4'd1, 4'd2, 4'd3, 4'd4, 4'd6, 4'd12: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] months_between(logic [3:0] p);
    logic [3:0] m;
    case (p)
      4'd1:    m = 4'd12;
      4'd2:    m = 4'd6;
      4'd3:    m = 4'd4;
      4'd4:    m = 4'd3;
      4'd6:    m = 4'd2;
      default: m = 4'd1;
    endcase
    return m;
  endfunction

endpackage

@@ hw/rtl/ulcf_serial_mul.sv @@
// Bit-serial rounded fixed-point multiplier, one multiplier bit per cycle.
// Depends on ulcf_pkg.
module ulcf_serial_mul (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ulcf_pkg::unit_req_t req_i,
  output ulcf_pkg::unit_rsp_t rsp_o
);
  import ulcf_pkg::*;

  localparam int CNT_W = $clog2(SERIAL_STEPS + 1);

  logic [CNT_W-1:0] cnt_q;
  logic             done_q;
  logic [OP_W-1:0]  a_q, b_q, acc_q, low_q;
  logic [OP_W:0]    sum;

  assign sum = {1'b0, acc_q} + (b_q[0] ? {1'b0, a_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (req_i.start) begin
      cnt_q  <= CNT_W'(SERIAL_STEPS);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - CNT_W'(1);
      done_q <= (cnt_q == CNT_W'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q   <= req_i.a;
      b_q   <= req_i.b;
      acc_q <= '0;
      low_q <= '0;
    end else if (cnt_q != '0) begin
      // shift the product right, one bit leaves into the low half
      acc_q <= sum[OP_W:1];
      low_q <= {sum[0], low_q[OP_W-1:1]};
      b_q   <= {1'b0, b_q[OP_W-1:1]};
    end
  end

  // round half up at bit 31
  assign rsp_o.done = done_q;
  assign rsp_o.res  = {acc_q, low_q[35:32]} + RES_W'(low_q[31]);

endmodule

@@ hw/rtl/ulcf_serial_div.sv @@
// Bit-serial restoring divider giving round(a * 2^32 / b), one quotient bit per cycle.
// Depends on ulcf_pkg.
module ulcf_serial_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ulcf_pkg::unit_req_t req_i,
  output ulcf_pkg::unit_rsp_t rsp_o
);
  import ulcf_pkg::*;

  localparam int CNT_W = $clog2(SERIAL_STEPS + 1);

  logic [CNT_W-1:0] cnt_q;
  logic             done_q;
  logic [OP_W-1:0]  r_q, d_q, q_q, b_q;
  logic [OP_W:0]    trial, diff, rounded;
  logic             ge;

  assign trial   = {r_q, d_q[OP_W-1]};
  assign diff    = trial - {1'b0, b_q};
  assign ge      = trial >= {1'b0, b_q};
  assign rounded = {1'b0, q_q} + (OP_W + 1)'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (req_i.start) begin
      cnt_q  <= CNT_W'(SERIAL_STEPS);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - CNT_W'(1);
      done_q <= (cnt_q == CNT_W'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  // dividend is a << 33; the quotient has one guard bit for rounding
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      r_q <= {3'b000, req_i.a[OP_W-1:3]};
      d_q <= {req_i.a[2:0], 33'd0};
      q_q <= '0;
      b_q <= req_i.b;
    end else if (cnt_q != '0) begin
      r_q <= ge ? diff[OP_W-1:0] : trial[OP_W-1:0];
      d_q <= {d_q[OP_W-2:0], 1'b0};
      q_q <= {q_q[OP_W-2:0], ge};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = RES_W'(rounded[OP_W:1]);

endmodule

@@ hw/rtl/ulcf_year_store.sv @@
// Per-year table memory: one write port, one registered read port.
// Depends on ulcf_pkg for the entry layout.
module ulcf_year_store #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  ulcf_pkg::entry_t wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output ulcf_pkg::entry_t rdata_o
);
  import ulcf_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

@@ hw/rtl/ul_commutation_functions_unit.sv @@
// Universal-life commutation table unit, built one policy year at a time.
// Input channel (valid/stall) carries load or read words; output channel
// (valid/stall) returns one result word for each input word.
// Configuration channel (valid/ready, always ready) sets the deduction
// periods per year and death benefit option 2; write it only while idle.
// A load runs a sequencer over a bit-serial multiplier and a bit-serial
// divider, with 10 + m + p operations a year (p periods, m = 12/p months
// between deductions).
// A read goes through a registered memory read, a step to form the
// backward sums, and a load into the output register.
// One word is in work at a time; the input stalls until its result is in
// the output register, which may still be waiting for the receiver.
// A stalled receiver holds the result; a finished word waits behind it.
// Reset empties the table and returns the configuration to 12 periods,
// option 1. The table memory needs no clearing.
// Depends on ulcf_pkg, ulcf_serial_mul, ulcf_serial_div, ulcf_year_store.
module ul_commutation_functions_unit #(
  parameter int MAX_YEARS = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        in_operation_i,
  input  logic [6:0]  in_year_i,
  input  logic [31:0] in_mortality_rate_i,
  input  logic [31:0] in_credited_rate_i,
  input  logic [31:0] in_guaranteed_rate_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  out_status_o,
  output logic [32:0] out_discount_factor_o,
  output logic [35:0] out_annuity_value_o,
  output logic [35:0] out_claim_value_o,
  output logic [39:0] out_annuity_backsum_o,
  output logic [42:0] out_claim_backsum_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [3:0]  cfg_data_i
);
  import ulcf_pkg::*;

  localparam int AW = (MAX_YEARS > 1) ? $clog2(MAX_YEARS) : 1;
  localparam int YW = $clog2(MAX_YEARS + 1);
  localparam int CW = (YW > 7) ? YW : 7;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ISSUE = 5'b00010,
    S_WAIT  = 5'b00100,
    S_READ  = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  typedef enum logic [3:0] {
    SP_NUM, SP_F, SP_IGF, SP_I, SP_Q, SP_VP, SP_VQ,
    SP_XM, SP_TERM, SP_KD, SP_KC, SP_NEXT
  } step_e;

  state_e state_q, state_d;
  step_e  step_q, step_d;
  logic [3:0]    cnt_q, cnt_d;
  logic [YW-1:0] years_q, years_d;
  logic [32:0]   nd_q, nd_d;
  logic [39:0]   dtot_q, dtot_d;
  logic [42:0]   ctot_q, ctot_d;
  logic [3:0]    periods_q;
  logic          option_q;

  logic [32:0] qc_q, qc_d, ic_q, ic_d, ig_q, ig_d;
  logic [39:0] tmp_q, tmp_d;
  logic [35:0] f_q, f_d, i_q, i_d, vq_q, vq_d, ka_q, ka_d, kd_q, kd_d, kc_q, kc_d;
  logic [32:0] q_q, q_d, vp_q, vp_d, xm_q, xm_d, term_q, term_d;

  logic [1:0]  rs_status_q, rs_status_d;
  logic [32:0] rs_ad_q, rs_ad_d;
  logic [35:0] rs_kd_q, rs_kd_d, rs_kc_q, rs_kc_d;
  logic [39:0] rs_an_q, rs_an_d;
  logic [42:0] rs_km_q, rs_km_d;

  logic        out_valid_q, out_valid_d;

  unit_req_t mul_req, div_req;
  unit_rsp_t mul_rsp, div_rsp;
  logic [OP_W-1:0]  op_a, op_b;
  logic             is_div, unit_done;
  logic [RES_W-1:0] res;

  logic        accept, in_range, load_ok, out_free;
  logic        mem_we, mem_re;
  entry_t      mem_wdata, mem_rdata;
  logic [32:0] q_clamped;
  logic [40:0] dsum;
  logic [43:0] csum;
  logic [39:0] dtot_new;
  logic [42:0] ctot_new;
  logic [3:0]  months;

  function automatic logic [32:0] clamp_rate(logic [31:0] x);
    return {(x > RATE_MAX) ? RATE_MAX : x, 1'b0};
  endfunction

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign months      = months_between(periods_q);
  assign in_range    = CW'(in_year_i) < CW'(years_q);
  assign load_ok     = (in_year_i == 7'd0) ||
                       ((CW'(in_year_i) == CW'(years_q)) && (years_q < YW'(MAX_YEARS)));

  always_comb begin
    is_div = 1'b0;
    op_a   = '0;
    op_b   = '0;
    unique case (step_q)
      SP_NUM:  begin op_a = 36'(qc_q);  op_b = 36'(FX_ONE) + 36'(ic_q); end
      SP_F:    begin is_div = 1'b1; op_a = tmp_q[35:0]; op_b = 36'(FX_ONE) + 36'(ig_q); end
      SP_IGF:  begin op_a = 36'(ig_q);  op_b = f_q; end
      SP_I:    begin
        is_div = 1'b1;
        op_a   = 36'(ic_q) + tmp_q[35:0];
        op_b   = 36'(FX_ONE) + f_q;
      end
      SP_Q:    begin is_div = 1'b1; op_a = f_q; op_b = 36'(FX_ONE) + f_q; end
      SP_VP:   begin is_div = 1'b1; op_a = 36'(FX_ONE - q_q); op_b = i_q; end
      SP_VQ:   begin is_div = 1'b1; op_a = 36'(q_q); op_b = i_q; end
      SP_XM:   begin op_a = 36'(xm_q);   op_b = 36'(vp_q); end
      SP_TERM: begin op_a = 36'(term_q); op_b = 36'(xm_q); end
      SP_KD:   begin op_a = ka_q;        op_b = 36'(nd_q); end
      SP_KC:   begin op_a = kd_q;        op_b = vq_q; end
      SP_NEXT: begin op_a = 36'(nd_q);   op_b = 36'(term_q); end
      default: ;
    endcase
  end

  assign mul_req.start = (state_q == S_ISSUE) && !is_div;
  assign mul_req.a     = op_a;
  assign mul_req.b     = op_b;
  assign div_req.start = (state_q == S_ISSUE) && is_div;
  assign div_req.a     = op_a;
  assign div_req.b     = op_b;
  assign unit_done     = is_div ? div_rsp.done : mul_rsp.done;
  assign res           = is_div ? div_rsp.res : mul_rsp.res;

  assign q_clamped = (res > RES_W'(FX_ONE)) ? FX_ONE : res[32:0];
  assign dsum      = {1'b0, dtot_q} + 41'(nd_q);
  assign csum      = {1'b0, ctot_q} + 44'(kc_q);
  assign dtot_new  = dsum[40] ? '1 : dsum[39:0];
  assign ctot_new  = csum[43] ? '1 : csum[42:0];

  assign mem_we    = (state_q == S_WAIT) && (step_q == SP_NEXT) && unit_done;
  assign mem_re    = accept && in_operation_i && in_range;
  assign mem_wdata = '{ad: nd_q, kd: kd_q, kc: kc_q, dpre: dtot_q, cpre: ctot_q};

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    cnt_d       = cnt_q;
    years_d     = years_q;
    nd_d        = nd_q;
    dtot_d      = dtot_q;
    ctot_d      = ctot_q;
    qc_d = qc_q;  ic_d = ic_q;  ig_d = ig_q;  tmp_d = tmp_q;
    f_d = f_q;    i_d = i_q;    q_d = q_q;    vp_d = vp_q;  vq_d = vq_q;
    xm_d = xm_q;  term_d = term_q;  ka_d = ka_q;  kd_d = kd_q;  kc_d = kc_q;
    rs_status_d = rs_status_q;
    rs_ad_d     = rs_ad_q;
    rs_kd_d     = rs_kd_q;
    rs_kc_d     = rs_kc_q;
    rs_an_d     = rs_an_q;
    rs_km_d     = rs_km_q;
    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          rs_ad_d = '0;
          rs_kd_d = '0;
          rs_kc_d = '0;
          rs_an_d = '0;
          rs_km_d = '0;
          if (in_operation_i) begin
            rs_status_d = ST_UNLOADED;
            state_d     = in_range ? S_READ : S_DONE;
          end else begin
            if (in_year_i == 7'd0) begin
              years_d = '0;
              nd_d    = FX_ONE;
              dtot_d  = '0;
              ctot_d  = '0;
            end
            if (load_ok) begin
              qc_d    = clamp_rate(in_mortality_rate_i);
              ic_d    = clamp_rate(in_credited_rate_i);
              ig_d    = clamp_rate(in_guaranteed_rate_i);
              step_d  = SP_NUM;
              state_d = S_ISSUE;
            end else begin
              rs_status_d = ST_SEQ;
              state_d     = S_DONE;
            end
          end
        end
      end
      S_ISSUE: state_d = S_WAIT;
      S_WAIT: begin
        if (unit_done) begin
          state_d = S_ISSUE;
          case (step_q)
            SP_NUM:  begin tmp_d = res; step_d = SP_F; end
            SP_F:    begin f_d = res[35:0]; step_d = SP_IGF; end
            SP_IGF:  begin tmp_d = res; step_d = SP_I; end
            SP_I:    begin i_d = res[35:0]; step_d = SP_Q; end
            SP_Q: begin
              // i becomes the divisor 1 + i, less q under option 2
              q_d    = q_clamped;
              i_d    = 36'(FX_ONE) + i_q - (option_q ? 36'(q_clamped) : 36'd0);
              step_d = SP_VP;
            end
            SP_VP:   begin vp_d = q_clamped; step_d = SP_VQ; end
            SP_VQ: begin
              vq_d   = res[35:0];
              xm_d   = FX_ONE;
              term_d = FX_ONE;
              ka_d   = '0;
              cnt_d  = '0;
              step_d = SP_XM;
            end
            SP_XM: begin
              xm_d = res[32:0];
              if (cnt_q + 4'd1 == months) begin
                cnt_d  = '0;
                step_d = SP_TERM;
              end else begin
                cnt_d = cnt_q + 4'd1;
              end
            end
            SP_TERM: begin
              ka_d   = ka_q + 36'(term_q);
              term_d = res[32:0];
              if (cnt_q + 4'd1 == periods_q) begin
                cnt_d  = '0;
                step_d = SP_KD;
              end else begin
                cnt_d = cnt_q + 4'd1;
              end
            end
            SP_KD: begin
              kd_d   = (res > RES_W'(KC_MAX)) ? KC_MAX : res[35:0];
              step_d = SP_KC;
            end
            SP_KC: begin
              kc_d   = (res > RES_W'(KC_MAX)) ? KC_MAX : res[35:0];
              step_d = SP_NEXT;
            end
            default: begin
              // commit the year and present it as a read would
              nd_d        = q_clamped;
              dtot_d      = dtot_new;
              ctot_d      = ctot_new;
              years_d     = years_q + YW'(1);
              rs_status_d = ST_OK;
              rs_ad_d     = nd_q;
              rs_kd_d     = kd_q;
              rs_kc_d     = kc_q;
              rs_an_d     = dtot_new - dtot_q;
              rs_km_d     = ctot_new - ctot_q;
              state_d     = S_DONE;
            end
          endcase
        end
      end
      S_READ: begin
        rs_status_d = ST_OK;
        rs_ad_d     = mem_rdata.ad;
        rs_kd_d     = mem_rdata.kd;
        rs_kc_d     = mem_rdata.kc;
        rs_an_d     = dtot_q - mem_rdata.dpre;
        rs_km_d     = ctot_q - mem_rdata.cpre;
        state_d     = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= SP_NUM;
      cnt_q       <= '0;
      years_q     <= '0;
      nd_q        <= FX_ONE;
      dtot_q      <= '0;
      ctot_q      <= '0;
      periods_q   <= 4'd12;
      option_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      cnt_q       <= cnt_d;
      years_q     <= years_d;
      nd_q        <= nd_d;
      dtot_q      <= dtot_d;
      ctot_q      <= ctot_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_PERIODS && periods_ok(cfg_data_i)) begin
          periods_q <= cfg_data_i;
        end else if (cfg_index_i == CFG_OPTION) begin
          option_q <= cfg_data_i[0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    qc_q <= qc_d;  ic_q <= ic_d;  ig_q <= ig_d;  tmp_q <= tmp_d;
    f_q <= f_d;    i_q <= i_d;    q_q <= q_d;    vp_q <= vp_d;  vq_q <= vq_d;
    xm_q <= xm_d;  term_q <= term_d;  ka_q <= ka_d;  kd_q <= kd_d;  kc_q <= kc_d;
    rs_status_q <= rs_status_d;
    rs_ad_q     <= rs_ad_d;
    rs_kd_q     <= rs_kd_d;
    rs_kc_q     <= rs_kc_d;
    rs_an_q     <= rs_an_d;
    rs_km_q     <= rs_km_d;
    // load the output word only when it is free
    if (state_q == S_DONE && out_free) begin
      out_status_o          <= rs_status_q;
      out_discount_factor_o <= rs_ad_q;
      out_annuity_value_o   <= rs_kd_q;
      out_claim_value_o     <= rs_kc_q;
      out_annuity_backsum_o <= rs_an_q;
      out_claim_backsum_o   <= rs_km_q;
    end
  end

  assign out_valid_o = out_valid_q;

  ulcf_serial_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  ulcf_serial_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  ulcf_year_store #(
    .DEPTH (MAX_YEARS),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (years_q[AW-1:0]),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (AW'(in_year_i)),
    .rdata_o (mem_rdata)
  );

endmodule

@@ hw/rtl/ulcf_checker.sv @@
// Port-level checks of the commutation unit, bound to its top level.
// Depends on ulcf_pkg and ul_commutation_functions_unit.
module ulcf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  out_status_o,
  input logic [32:0] out_discount_factor_o,
  input logic [35:0] out_annuity_value_o,
  input logic [35:0] out_claim_value_o,
  input logic [39:0] out_annuity_backsum_o,
  input logic [42:0] out_claim_backsum_o
);
  import ulcf_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_status_o) &&
    $stable(out_discount_factor_o) && $stable(out_claim_backsum_o))
    else $error("stalled output word changed");

  a_one_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second word taken while one is in work");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_status_o != 2'd3)
    else $error("undefined status code");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_status_o != ST_OK |->
    out_discount_factor_o == '0 && out_annuity_value_o == '0 &&
    out_claim_value_o == '0 && out_annuity_backsum_o == '0 &&
    out_claim_backsum_o == '0)
    else $error("error word carries data");

endmodule

bind ul_commutation_functions_unit ulcf_checker u_ulcf_checker (.*);
